FILE: hw/rtl/jcs_pkg.sv
// shared types and character constants for the comment stripper
package jcs_pkg;

    // characters that steer the scanner
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // one queue entry: the one or two results caused by one input item
    typedef struct packed {
        logic [7:0] byte0;
        logic       bv0;
        logic [7:0] byte1;
        logic       two;
        logic       last;
    } t_entry;

endpackage

FILE: hw/rtl/jcs_if.sv
// valid/ready channel interfaces for the input and result streams
interface jcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output byte_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input out_last,
                    output ready);
endinterface

FILE: hw/rtl/json_comment_stripper_top.sv
// top level of the C-style comment stripper
//
// Usage: text enters on i_in, one byte per item with in_last on the final
// byte. Stripped text leaves on o_out, one byte per item; byte_valid is 0
// only on a bare end marker, and out_last marks the final item of a stream.
// Quoted strings and their escapes pass unchanged, comments are dropped,
// a line comment's newline is kept, a trailing held slash is flushed.
// Path: a byte that produces output is written into the entry queue, then
// loaded into the output register; the second byte of a pair follows the first.
// Throughput: one input item per cycle while the queue is not full; an item
// that produces two output bytes (held slash plus the next byte) leaves as
// two results, which the entry queue of FIFO_DEPTH entries absorbs.
// The output rate is bounded by the single output register: one item per
// cycle while o_out.ready is high.
// Reset: synchronous, active low; the scanner returns to plain text and
// the queue and output stage empty. No clearing pass is needed.
// Stalls: when o_out.ready is low the output holds; the queue keeps
// taking input until it fills, then i_in.ready drops.
module json_comment_stripper_top
    import jcs_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jcs_in_if.sink    i_in,
    jcs_out_if.source o_out
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;

    // mode machine
    jcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // entry queue
    jcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    // output stage
    jcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: hw/rtl/jcs_front.sv
// front end: scan mode machine that turns each input item into a queue entry
module jcs_front
    import jcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    jcs_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);

    typedef enum logic [2:0] {
        M_PLAIN      = 3'd0,
        M_STRING     = 3'd1,
        M_ESCAPE     = 3'd2,
        M_SLASH      = 3'd3,
        M_LINE       = 3'd4,
        M_BLOCK      = 3'd5,
        M_BLOCK_STAR = 3'd6
    } t_mode;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] c;
    logic       accept;

    assign c      = i_in.in_byte;
    assign i_in.ready = !i_full;
    assign accept = i_in.valid && !i_full;

    // next mode and the bytes this item produces
    always_comb begin
        n_mode = r_mode;
        cnt    = 2'd0;
        b0     = 8'h00;
        b1     = 8'h00;
        case (r_mode)
            M_STRING: begin
                b0  = c;
                cnt = 2'd1;
                if (c == CH_BACKSLASH) begin
                    n_mode = M_ESCAPE;
                end else if (c == CH_QUOTE) begin
                    n_mode = M_PLAIN;
                end
            end
            M_ESCAPE: begin
                b0     = c;
                cnt    = 2'd1;
                n_mode = M_STRING;
            end
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    n_mode = M_LINE;
                end else if (c == CH_STAR) begin
                    n_mode = M_BLOCK;
                end else begin
                    // held slash goes out, then the byte as plain text
                    b0     = CH_SLASH;
                    b1     = c;
                    cnt    = 2'd2;
                    n_mode = (c == CH_QUOTE) ? M_STRING : M_PLAIN;
                end
            end
            M_LINE: begin
                if (c == CH_NEWLINE) begin
                    b0     = c;
                    cnt    = 2'd1;
                    n_mode = M_PLAIN;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) begin
                    n_mode = M_BLOCK_STAR;
                end
            end
            M_BLOCK_STAR: begin
                if (c == CH_SLASH) begin
                    n_mode = M_PLAIN;
                end else if (c != CH_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            default: begin
                if (c == CH_QUOTE) begin
                    b0     = c;
                    cnt    = 2'd1;
                    n_mode = M_STRING;
                end else if (c == CH_SLASH) begin
                    n_mode = M_SLASH;
                end else begin
                    b0     = c;
                    cnt    = 2'd1;
                    n_mode = M_PLAIN;
                end
            end
        endcase

        // end of stream: flush a held slash and restart in plain text
        if (i_in.in_last) begin
            if (n_mode == M_SLASH) begin
                if (cnt == 2'd0) begin
                    b0  = CH_SLASH;
                    cnt = 2'd1;
                end else begin
                    b1  = CH_SLASH;
                    cnt = 2'd2;
                end
            end
            n_mode = M_PLAIN;
        end
    end

    // queue entry; a last item with no byte becomes a bare end marker
    assign o_push        = accept && ((cnt != 2'd0) || i_in.in_last);
    assign o_entry.byte0 = b0;
    assign o_entry.bv0   = (cnt != 2'd0);
    assign o_entry.byte1 = b1;
    assign o_entry.two   = (cnt == 2'd2);
    assign o_entry.last  = i_in.in_last;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_PLAIN;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

FILE: hw/rtl/jcs_fifo.sv
// short entry queue between the front end and the output stage
module jcs_fifo
    import jcs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty,
    output logic   o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/jcs_back.sv
// back end: splits queue entries into results in a registered output stage
module jcs_back
    import jcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    jcs_out_if.source o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_last;
    logic       r_phase;
    logic       load;
    logic       take;

    assign load  = !r_valid || o_out.ready;
    assign take  = load && !i_empty;
    assign o_pop = take && (r_phase || !i_head.two);

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.byte_valid = r_bv;
    assign o_out.out_last   = r_last;

    // output register; second result of an entry follows the first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                if (r_phase) begin
                    r_phase <= 1'b0;
                end else begin
                    r_phase <= i_head.two;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_phase) begin
                r_byte <= i_head.byte1;
                r_bv   <= 1'b1;
                r_last <= i_head.last;
            end else begin
                r_byte <= i_head.byte0;
                r_bv   <= i_head.bv0;
                r_last <= i_head.last && !i_head.two;
            end
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench for the comment stripper: directed and random text streams, scoreboard check

import jcs_pkg::*;

// scanner modes of the expected-text model
typedef enum logic [2:0] {
    M_PLAIN,
    M_STRING,
    M_ESCAPE,
    M_SLASH,
    M_LINE,
    M_BLOCK,
    M_BLOCK_STAR
} scan_mode_e;

// one result item as it should leave the block
typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
} text_result_t;

// keeps the stripped text expected from every accepted item and checks results against it
class strip_scoreboard;
    scan_mode_e   mode;
    text_result_t expected_text[$];
    int           n_errors;
    int           n_checked;
    int           n_markers;
    int           n_pairs;

    function new();
        mode      = M_PLAIN;
        n_errors  = 0;
        n_checked = 0;
        n_markers = 0;
        n_pairs   = 0;
    endfunction

    function void push_text(logic [7:0] b, logic bv);
        expected_text.push_back('{b, bv, 1'b0});
    endfunction

    // a byte seen outside strings and comments
    function void take_plain(logic [7:0] c);
        if (c == CH_QUOTE) begin
            push_text(c, 1'b1);
            mode = M_STRING;
        end else if (c == CH_SLASH) begin
            mode = M_SLASH;
        end else begin
            push_text(c, 1'b1);
            mode = M_PLAIN;
        end
    endfunction

    // works out the results caused by one accepted input item
    function void strip_byte(logic [7:0] c, logic fin);
        int           first;
        text_result_t r;
        first = expected_text.size();
        case (mode)
            M_STRING: begin
                push_text(c, 1'b1);
                if (c == CH_BACKSLASH)
                    mode = M_ESCAPE;
                else if (c == CH_QUOTE)
                    mode = M_PLAIN;
            end
            M_ESCAPE: begin
                push_text(c, 1'b1);
                mode = M_STRING;
            end
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    mode = M_LINE;
                end else if (c == CH_STAR) begin
                    mode = M_BLOCK;
                end else begin
                    push_text(CH_SLASH, 1'b1);
                    take_plain(c);
                end
            end
            M_LINE: begin
                if (c == CH_NEWLINE) begin
                    push_text(c, 1'b1);
                    mode = M_PLAIN;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR)
                    mode = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (c == CH_SLASH)
                    mode = M_PLAIN;
                else if (c != CH_STAR)
                    mode = M_BLOCK;
            end
            default: begin
                take_plain(c);
            end
        endcase
        // end of stream: flush a held slash, or send a bare end marker
        if (fin) begin
            if (mode == M_SLASH)
                push_text(CH_SLASH, 1'b1);
            if (expected_text.size() == first) begin
                push_text(8'h00, 1'b0);
                n_markers++;
            end
            r = expected_text[$];
            r.end_of_text = 1'b1;
            expected_text[$] = r;
            mode = M_PLAIN;
        end
        if (expected_text.size() - first == 2)
            n_pairs++;
    endfunction

    // compares one accepted result with the oldest expected one
    function void check_result(logic [7:0] b, logic bv, logic fin);
        text_result_t want;
        n_checked++;
        if (expected_text.size() == 0) begin
            $error("unexpected result: out_byte %0h byte_valid %0b out_last %0b", b, bv, fin);
            n_errors++;
            return;
        end
        want = expected_text.pop_front();
        if (b !== want.text_byte) begin
            $error("out_byte: expected %0h, got %0h", want.text_byte, b);
            n_errors++;
        end
        if (bv !== want.has_byte) begin
            $error("byte_valid: expected %0b, got %0b", want.has_byte, bv);
            n_errors++;
        end
        if (fin !== want.end_of_text) begin
            $error("out_last: expected %0b, got %0b", want.end_of_text, fin);
            n_errors++;
        end
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS   = 550;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk;
    logic i_rst_n;

    jcs_in_if  in_ch();
    jcs_out_if out_ch();

    json_comment_stripper_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    strip_scoreboard board = new();

    logic [7:0] stream_q[$];
    bit         no_idle;
    int         n_items;
    int         n_streams;
    int         idle_cycles = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles, %0d results still expected",
                         WATCHDOG_LIMIT, board.expected_text.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: random stalls, check every accepted item
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            board.check_result(out_ch.out_byte, out_ch.byte_valid, out_ch.out_last);
        end
    end

    // one input item, after a random gap
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= fin;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        board.strip_byte(b, fin);
        n_items++;
    endtask

    // sends stream_q with the end flag on its final byte
    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
        n_streams++;
    endtask

    // directed text: '#' stands for 8'h00 and '~' for 8'hFF
    task automatic send_text(input string s);
        logic [7:0] c;
        stream_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == "#")
                c = 8'h00;
            else if (c == "~")
                c = 8'hFF;
            stream_q.push_back(c);
        end
        send_stream();
    endtask

    // body byte biased toward the characters that steer the scanner
    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 7))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_QUOTE;
            3: return CH_BACKSLASH;
            4: return CH_NEWLINE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // random stream built from strings, comments, held slashes and noise
    task automatic build_stream();
        stream_q.delete();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1: stream_q.push_back(text_char());
                2, 3: begin
                    stream_q.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 3) == 0)
                            stream_q.push_back(CH_BACKSLASH);
                        stream_q.push_back(text_char());
                    end
                    if ($urandom_range(0, 5) != 0)
                        stream_q.push_back(CH_QUOTE);
                end
                4, 5: begin
                    stream_q.push_back(CH_SLASH);
                    stream_q.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 4))
                        stream_q.push_back(text_char());
                    if ($urandom_range(0, 5) != 0)
                        stream_q.push_back(CH_NEWLINE);
                end
                6, 7: begin
                    stream_q.push_back(CH_SLASH);
                    stream_q.push_back(CH_STAR);
                    repeat ($urandom_range(0, 4))
                        stream_q.push_back(text_char());
                    if ($urandom_range(0, 5) != 0) begin
                        stream_q.push_back(CH_STAR);
                        stream_q.push_back(CH_SLASH);
                    end
                end
                8: begin
                    stream_q.push_back(CH_SLASH);
                    stream_q.push_back(text_char());
                end
                default: begin
                    repeat ($urandom_range(1, 3))
                        stream_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        no_idle       = 1'b0;
        n_items       = 0;
        n_streams     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // held slash alone at the end is flushed
        send_text("/");
        // held slash then a quote: two results, string left open
        send_text("/\"");
        // slash emitted, line comment keeps its newline, extreme bytes
        send_text("/x//~\n#");
        // star-slash after the opening star does not close, block ends silently
        send_text("/*/*~**/");
        // escaped quote and comment opener inside a string pass through
        send_text("\"\\\"/*\"");
        // line comment to the end gives a bare end marker
        send_text("//");
        // backslash as the final byte inside a string is emitted
        send_text("\"\\");

        // random streams, with some stretches free of idling
        while (n_items < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            build_stream();
            send_stream();
        end
        in_ch.valid <= 1'b0;
        no_idle = 1'b0;

        while (board.expected_text.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d items in %0d streams; checked %0d results", n_items, n_streams,
                 board.n_checked);
        $display("end markers: %0d, items with two results: %0d", board.n_markers,
                 board.n_pairs);
        if (board.n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
